>>> hdl/tpf_pkg.sv
// ----------------------------------------------------------------------------
// tpf_pkg
// Shared constants, types and single-precision arithmetic helpers for the
// tan(pi*x) pipeline: split add and multiply steps and a common round/pack.
// ----------------------------------------------------------------------------
package tpf_pkg;

  localparam logic [31:0] QuietBit = 32'h0040_0000;
  localparam logic [31:0] CanonNan = 32'h7fc0_0000;
  localparam logic [31:0] PosInf   = 32'h7f80_0000;
  localparam logic [31:0] NegInf   = 32'hff80_0000;
  localparam logic [31:0] OneF     = 32'h3f80_0000;
  localparam logic [31:0] QuarterF = 32'h3e80_0000;
  localparam logic [31:0] ThreeQF  = 32'h3f40_0000;
  localparam logic [31:0] NegHalfF = 32'hbf00_0000;
  localparam logic [31:0] NegOneF  = 32'hbf80_0000;
  localparam logic [31:0] CoefA    = 32'h4049_0fda;
  localparam logic [31:0] CoefB    = 32'h403e_1b93;
  localparam logic [31:0] CoefC    = 32'h4087_8857;
  localparam logic [31:0] CoefD    = 32'h3f72_4cd0;

  localparam int DivSteps  = 3;
  localparam int DivStages = 9;

  typedef logic signed [9:0] exp_t;

  typedef struct packed {
    logic        s;
    exp_t        e;
    logic [50:0] sum;
    logic        st;
  } add_mid_t;

  typedef struct packed {
    logic        s;
    exp_t        e;
    logic [47:0] p;
  } mul_mid_t;

  typedef struct packed {
    logic        special;
    logic [31:0] special_res;
    logic        int_even;
    logic        neg_flip;
    logic        cot;
  } side_t;

  function automatic exp_t unpack_e(logic [31:0] a);
    exp_t r;
    if (a[30:23] == 8'd0) r = -exp_t'(126);
    else r = exp_t'({2'b00, a[30:23]}) - exp_t'(127);
    return r;
  endfunction

  function automatic logic [23:0] unpack_m(logic [31:0] a);
    return {a[30:23] != 8'd0, a[22:0]};
  endfunction

  function automatic logic [6:0] lzc64(logic [63:0] v);
    logic [6:0] r;
    r = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = 7'(63 - i);
    end
    return r;
  endfunction

  // value = m / 2^26 * 2^e, m[26] set unless zero
  function automatic logic [31:0] round_pack(logic s, exp_t e, logic [26:0] m, logic st);
    logic signed [11:0] be;
    logic [8:0]         sh;
    logic [26:0]        mm;
    logic [7:0]         fld;
    logic               sticky;
    logic               inc;
    logic [30:0]        mag;
    logic [31:0]        r;
    be     = {{2{e[9]}}, e} + 12'sd127;
    sticky = st;
    mm     = m;
    fld    = be[7:0];
    sh     = '0;
    if (m == 27'd0) begin
      r = {s, 31'd0};
    end else if (be >= 12'sd255) begin
      r = {s, 8'hff, 23'd0};
    end else begin
      if (be <= 12'sd0) begin
        sh     = 9'(12'sd1 - be);
        sticky = st | (|(m & ((27'd1 << sh) - 27'd1)));
        mm     = m >> sh;
        fld    = 8'd0;
      end
      inc = mm[2] & (mm[1] | mm[0] | sticky | mm[3]);
      mag = {fld, mm[25:3]} + 31'(inc);
      r   = {s, mag};
    end
    return r;
  endfunction

  function automatic add_mid_t fadd_a(logic [31:0] a, logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    exp_t        ex;
    exp_t        ey;
    logic [9:0]  d;
    logic [49:0] big;
    logic [49:0] sml;
    logic [49:0] shf;
    logic        st;
    logic [50:0] sum;
    add_mid_t    r;
    if (b[30:0] > a[30:0]) begin
      x = b;
      y = a;
    end else begin
      x = a;
      y = b;
    end
    ex  = unpack_e(x);
    ey  = unpack_e(y);
    d   = 10'(ex - ey);
    big = {unpack_m(x), 26'd0};
    sml = {unpack_m(y), 26'd0};
    st  = |(sml & ((50'd1 << d) - 50'd1));
    shf = sml >> d;
    if (x[31] ^ y[31]) sum = {1'b0, big} - {1'b0, shf} - 51'(st);
    else sum = {1'b0, big} + {1'b0, shf};
    r.s   = (sum == 51'd0 && !st) ? (x[31] & y[31]) : x[31];
    r.e   = ex;
    r.sum = sum;
    r.st  = st;
    return r;
  endfunction

  function automatic logic [31:0] fadd_b(add_mid_t a);
    logic [6:0]  lz;
    logic [50:0] n;
    exp_t        e;
    lz = lzc64({a.sum, 13'd0});
    n  = a.sum << lz;
    e  = a.e + exp_t'(1) - exp_t'({3'b000, lz});
    return round_pack(a.s, e, n[50:24], (|n[23:0]) | a.st);
  endfunction

  function automatic mul_mid_t fmul_a(logic [31:0] a, logic [31:0] b);
    mul_mid_t r;
    r.s = a[31] ^ b[31];
    r.e = unpack_e(a) + unpack_e(b) + exp_t'(1);
    r.p = unpack_m(a) * unpack_m(b);
    return r;
  endfunction

  function automatic logic [31:0] fmul_b(mul_mid_t a);
    logic [6:0]  lz;
    logic [47:0] n;
    exp_t        e;
    lz = lzc64({a.p, 16'd0});
    n  = a.p << lz;
    e  = a.e - exp_t'({3'b000, lz});
    return round_pack(a.s, e, n[47:21], |n[20:0]);
  endfunction

endpackage

>>> hdl/tpf_div.sv
// ----------------------------------------------------------------------------
// tpf_div
// Pipelined single-precision divider, three quotient bits per stage, with
// final zero, pole and sign fix-up and a special-value select; pole sign,
// sign flip and special result come from the sideband.
module tpf_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [31:0]   top_i,
  input  logic [31:0]   bot_i,
  input  tpf_pkg::side_t side_i,
  output logic          valid_o,
  output logic [31:0]   result_o
);
  import tpf_pkg::*;

  typedef struct packed {
    logic        s;
    exp_t        e;
    logic [23:0] mb;
    logic [24:0] rem;
    logic [26:0] q;
    logic        zt;
    logic        zb;
    side_t       sd;
  } div_stage_t;

  function automatic div_stage_t div_iter(div_stage_t a);
    div_stage_t r;
    r = a;
    for (int k = 0; k < DivSteps; k++) begin
      if (r.rem >= {1'b0, r.mb}) begin
        r.q   = {r.q[25:0], 1'b1};
        r.rem = r.rem - {1'b0, r.mb};
      end else begin
        r.q = {r.q[25:0], 1'b0};
      end
      r.rem = {r.rem[23:0], 1'b0};
    end
    return r;
  endfunction

  div_stage_t          st_q [DivStages+1];
  logic [DivStages:0]  dv_q;
  div_stage_t          st0_d;
  logic [23:0]         mt;
  logic [23:0]         mbn;
  logic [6:0]          lzt;
  logic [6:0]          lzb;
  div_stage_t          fin;
  logic [26:0]         mq;
  exp_t                eq;
  logic [31:0]         rp;
  logic [31:0]         res;

  always_comb begin
    lzt          = lzc64({unpack_m(top_i), 40'd0});
    lzb          = lzc64({unpack_m(bot_i), 40'd0});
    mt           = 24'(unpack_m(top_i) << lzt);
    mbn          = 24'(unpack_m(bot_i) << lzb);
    st0_d.s      = top_i[31] ^ bot_i[31];
    st0_d.e      = (unpack_e(top_i) - exp_t'({3'b000, lzt}))
                 - (unpack_e(bot_i) - exp_t'({3'b000, lzb}));
    st0_d.mb     = mbn;
    st0_d.rem    = {1'b0, mt};
    st0_d.q      = '0;
    st0_d.zt     = top_i[30:0] == 31'd0;
    st0_d.zb     = bot_i[30:0] == 31'd0;
    st0_d.sd     = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en_i) begin
      dv_q <= {dv_q[DivStages-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar g = 1; g <= DivStages; g++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= div_iter(st_q[g-1]);
      end
    end
  end

  always_comb begin
    fin = st_q[DivStages];
    if (fin.q[26]) begin
      mq = fin.q;
      eq = fin.e;
    end else begin
      mq = {fin.q[25:0], 1'b0};
      eq = fin.e - exp_t'(1);
    end
    rp = round_pack(fin.s, eq, mq, |fin.rem);
    if (fin.zt) rp = {fin.s, 31'd0};
    if (fin.zb || rp[30:0] == PosInf[30:0]) begin
      rp = fin.sd.int_even ? PosInf : NegInf;
    end
    if (fin.sd.neg_flip) rp = {~rp[31], rp[30:0]};
    res = fin.sd.special ? fin.sd.special_res : rp;
  end

  assign valid_o  = dv_q[DivStages];
  assign result_o = res;

endmodule

>>> hdl/tanpi_float32.sv
// ----------------------------------------------------------------------------
// tanpi_float32
// tan(pi*x) in single precision: argument reduction, rounded polynomial
// evaluation and a pipelined divide, one request per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// throughput: one request per cycle unless the output stalls; add and
// multiply take two stages each, the divider three quotient bits per stage
// the whole pipe holds only while its last stage waits on a full output
// register; reset clears all valid bits, including the output valid
module tanpi_float32 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] x_bits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_bits_o
);
  import tpf_pkg::*;

  logic        en;
  logic        div_valid;
  logic [31:0] div_res;
  logic        out_valid_q;
  logic [31:0] out_q;
  logic [14:0] v_q;
  side_t       sd_q [1:14];

  logic [31:0] x_q;
  add_mid_t    am1_q;
  logic [31:0] f0_q;
  add_mid_t    am3_q;
  logic [31:0] f3p_q;
  logic        c1_q;
  logic [31:0] f4_q;
  mul_mid_t    m5a_q, m5b_q;
  logic [31:0] f5_q;
  logic [31:0] f6_q, f2_6_q, t1a6_q;
  mul_mid_t    m7a_q, m7b_q;
  logic [31:0] f7_q, t1a7_q;
  logic [31:0] f8_q, f3_8_q, t1a8_q, t1b8_q;
  mul_mid_t    m9a_q, m9b_q;
  add_mid_t    a9_q;
  logic [31:0] t1a9_q;
  logic [31:0] f4_10_q, t2a10_q, den0_10_q, t1a10_q;
  add_mid_t    a11_q;
  mul_mid_t    m11_q;
  logic [31:0] den0_11_q;
  logic [31:0] num12_q, t2b12_q, den0_12_q;
  add_mid_t    a13_q;
  logic [31:0] num13_q;
  logic [31:0] num14_q, den14_q;

  side_t       sd1_d;
  side_t       sd3_d;
  logic [31:0] abs_x;
  logic [31:0] floor_x;
  logic [4:0]  sh;
  logic [23:0] sig;
  logic        c1, c2;
  logic [31:0] top_sel, bot_sel;

  assign en         = !div_valid || !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    abs_x = {1'b0, x_q[30:0]};
    sig   = {1'b1, x_q[22:0]};
    sh    = 5'(8'd150 - x_q[30:23]);
    sd1_d.special     = x_q[30:23] == 8'hff;
    sd1_d.special_res = (x_q[22:0] != 23'd0) ? (abs_x | QuietBit) : CanonNan;
    sd1_d.neg_flip    = x_q[31] && (abs_x != 32'd0);
    sd1_d.cot         = 1'b0;
    if (x_q[30:23] < 8'd127) begin
      floor_x        = 32'd0;
      sd1_d.int_even = 1'b1;
    end else if (x_q[30:23] >= 8'd150) begin
      floor_x        = abs_x;
      sd1_d.int_even = 1'b1;
    end else begin
      floor_x        = abs_x & ~((32'd1 << sh) - 32'd1);
      sd1_d.int_even = ~sig[sh];
    end
  end

  always_comb begin
    c1        = f0_q[30:0] > QuarterF[30:0];
    c2        = f0_q[30:0] < ThreeQF[30:0];
    sd3_d     = sd_q[2];
    sd3_d.cot = c1 && c2;
  end

  always_comb begin
    top_sel = sd_q[14].cot ? {~den14_q[31], den14_q[30:0]} : num14_q;
    bot_sel = sd_q[14].cot ? num14_q : den14_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[13:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q        <= x_bits_i;
      sd_q[1]    <= sd1_d;
      am1_q      <= fadd_a(abs_x, {1'b1, floor_x[30:0]});
      sd_q[2]    <= sd_q[1];
      f0_q       <= fadd_b(am1_q);
      sd_q[3]    <= sd3_d;
      am3_q      <= fadd_a(f0_q, c2 ? NegHalfF : NegOneF);
      f3p_q      <= f0_q;
      c1_q       <= c1;
      sd_q[4]    <= sd_q[3];
      f4_q       <= c1_q ? fadd_b(am3_q) : f3p_q;
      sd_q[5]    <= sd_q[4];
      m5a_q      <= fmul_a(f4_q, f4_q);
      m5b_q      <= fmul_a(f4_q, CoefA);
      f5_q       <= f4_q;
      sd_q[6]    <= sd_q[5];
      f6_q       <= f5_q;
      f2_6_q     <= fmul_b(m5a_q);
      t1a6_q     <= fmul_b(m5b_q);
      sd_q[7]    <= sd_q[6];
      m7a_q      <= fmul_a(f2_6_q, f6_q);
      m7b_q      <= fmul_a(f2_6_q, CoefC);
      f7_q       <= f6_q;
      t1a7_q     <= t1a6_q;
      sd_q[8]    <= sd_q[7];
      f8_q       <= f7_q;
      f3_8_q     <= fmul_b(m7a_q);
      t1b8_q     <= fmul_b(m7b_q);
      t1a8_q     <= t1a7_q;
      sd_q[9]    <= sd_q[8];
      m9a_q      <= fmul_a(f3_8_q, f8_q);
      m9b_q      <= fmul_a(f3_8_q, CoefB);
      a9_q       <= fadd_a(OneF, {~t1b8_q[31], t1b8_q[30:0]});
      t1a9_q     <= t1a8_q;
      sd_q[10]   <= sd_q[9];
      f4_10_q    <= fmul_b(m9a_q);
      t2a10_q    <= fmul_b(m9b_q);
      den0_10_q  <= fadd_b(a9_q);
      t1a10_q    <= t1a9_q;
      sd_q[11]   <= sd_q[10];
      a11_q      <= fadd_a(t1a10_q, {~t2a10_q[31], t2a10_q[30:0]});
      m11_q      <= fmul_a(f4_10_q, CoefD);
      den0_11_q  <= den0_10_q;
      sd_q[12]   <= sd_q[11];
      num12_q    <= fadd_b(a11_q);
      t2b12_q    <= fmul_b(m11_q);
      den0_12_q  <= den0_11_q;
      sd_q[13]   <= sd_q[12];
      a13_q      <= fadd_a(den0_12_q, t2b12_q);
      num13_q    <= num12_q;
      sd_q[14]   <= sd_q[13];
      den14_q    <= fadd_b(a13_q);
      num14_q    <= num13_q;
    end
  end

  tpf_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (v_q[14]),
    .top_i    (top_sel),
    .bot_i    (bot_sel),
    .side_i   (sd_q[14]),
    .valid_o  (div_valid),
    .result_o (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && div_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && div_valid) begin
      out_q <= div_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_bits_o = out_q;

endmodule

>>> sim/tb_tanpi_float32.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tanpi_float32
// Self-checking bench for the tan(pi*x) unit. A bit-exact predictor built on
// double arithmetic, rounded to single after every step, checks every result
// in order. Stimulus covers directed corner values, random operands, bursts,
// output stalls and full back-pressure.
// ----------------------------------------------------------------------------
module tb_tanpi_float32;
  import tpf_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] x_bits_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] result_bits_o;

  logic [31:0] tan_q[$];
  int          err_cnt;
  int          cycle_cnt;
  int          burst_left;
  logic        rx_hold;
  int          rx_mode;

  tanpi_float32 dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .x_bits_i     (x_bits_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_bits_o(result_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic real to_real(logic [31:0] b);
    real v;
    if (b[30:23] == 8'd0) begin
      v = real'(b[22:0]) * 2.0 ** (-149);
      if (b[31]) v = -v;
    end else begin
      v = $bitstoreal({b[31], 11'({3'b000, b[30:23]}) + 11'd896, b[22:0], 29'd0});
    end
    return v;
  endfunction

  // round a double to single, nearest even, with subnormals
  function automatic logic [31:0] to_single(real v);
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] q;
    logic        rb;
    logic        st;
    logic [31:0] mag;
    int          fe;
    int          sh;
    b = $realtobits(v);
    if (b[62:0] == 63'd0) return {b[63], 31'd0};
    if (b[62:52] == 11'h7ff) return {b[63], PosInf[30:0]};
    m  = {11'd0, 1'b1, b[51:0]};
    fe = int'(b[62:52]) - 1023 + 127;
    if (fe >= 255) return {b[63], PosInf[30:0]};
    sh = (fe >= 1) ? 29 : 30 - fe;
    if (sh > 60) sh = 60;
    q  = m >> sh;
    rb = m[sh-1];
    st = |(m & ((64'd1 << (sh - 1)) - 64'd1));
    q  = q + 64'(rb & (st | q[0]));
    if (fe >= 1) mag = (32'(fe - 1) << 23) + 32'(q);
    else mag = 32'(q);
    if (mag >= PosInf) mag = PosInf;
    return {b[63], mag[30:0]};
  endfunction

  function automatic real rnd(real v);
    return to_real(to_single(v));
  endfunction

  function automatic logic [31:0] tanpi_of(logic [31:0] x);
    logic [31:0] ab;
    logic [31:0] fl;
    logic [31:0] r;
    logic        even;
    logic        c1;
    logic        c2;
    logic        cot;
    logic        pole;
    int          ex;
    int          sh;
    real         f;
    real         f2;
    real         f3;
    real         f4;
    real         num;
    real         den;
    real         top;
    real         bot;
    ab = {1'b0, x[30:0]};
    if (ab[30:23] == 8'hff) begin
      if (ab[22:0] != 23'd0) return ab | QuietBit;
      return CanonNan;
    end
    ex = int'(ab[30:23]) - 127;
    if (ex < 0) begin
      fl = 32'd0;
      even = 1'b1;
    end else if (ex >= 23) begin
      fl = ab;
      even = 1'b1;
    end else begin
      sh = 23 - ex;
      fl = ab & ~((32'd1 << sh) - 32'd1);
      even = ((({9'd1, ab[22:0]} >> sh) & 32'd1) == 32'd0);
    end
    f  = rnd(to_real(ab) - to_real(fl));
    c1 = f > 0.25;
    c2 = f < 0.75;
    if (c1) f = rnd(f - (c2 ? 0.5 : 1.0));
    f2  = rnd(f * f);
    f3  = rnd(f2 * f);
    f4  = rnd(f3 * f);
    num = rnd(rnd(f * to_real(CoefA)) - rnd(f3 * to_real(CoefB)));
    den = rnd(1.0 - rnd(f2 * to_real(CoefC)));
    den = rnd(den + rnd(f4 * to_real(CoefD)));
    cot = c1 & c2;
    top = cot ? -den : num;
    bot = cot ? num : den;
    pole = 1'b0;
    r = 32'd0;
    if (bot == 0.0) begin
      pole = 1'b1;
    end else begin
      r = to_single(top / bot);
      if (r[30:0] == PosInf[30:0]) pole = 1'b1;
    end
    if (pole) r = even ? PosInf : NegInf;
    if (x[31] && ab != 32'd0) r[31] = ~r[31];
    return r;
  endfunction

  task automatic report_err(input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at cycle %0d: result_bits got %h want %h", cycle_cnt, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tan_q.push_back(tanpi_of(x_bits_i));
      if (out_valid_o && out_ready_i) begin
        if (tan_q.size() == 0) begin
          $display("unexpected result %h at cycle %0d", result_bits_o, cycle_cnt);
          err_cnt++;
        end else begin
          if (result_bits_o !== tan_q[0]) report_err(result_bits_o, tan_q[0]);
          void'(tan_q.pop_front());
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 300000) begin
      $display("tb_tanpi_float32: errors");
      $finish;
    end
  end

  // receiver stall pattern: a randomly drawn mode sets out_ready_i; rx_hold forces it low
  always @(negedge clk_i) begin
    if (cycle_cnt % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (rx_hold) out_ready_i = 1'b0;
    else case (rx_mode)
      0, 1: out_ready_i = 1'b1;
      2: out_ready_i = 1'($urandom_range(0, 1));
      default: out_ready_i = ($urandom_range(0, 3) == 0);
    endcase
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_x(input logic [31:0] x);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    in_valid_i = 1'b1;
    x_bits_i   = x;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left--;
  endtask

  task automatic wait_drain();
    while (tan_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_x();
    logic [31:0] x;
    x = $urandom();
    case ($urandom_range(0, 9))
      0, 1: x[30:23] = 8'($urandom_range(100, 127));
      2, 3: x[30:23] = 8'($urandom_range(127, 140));
      4: x[30:0] = {8'd0, 23'($urandom)};
      5: x[30:23] = 8'($urandom_range(147, 160));
      6: x[30:23] = 8'hff;
      7: x[20:0] = 21'd0;
      default: ;
    endcase
    return x;
  endfunction

  task automatic test_directed();
    logic [31:0] vals[$];
    vals = {32'h0000_0000, 32'h8000_0000, 32'h3f00_0000, 32'h3fc0_0000, 32'hbf00_0000,
            32'h3e80_0000, 32'h3f40_0000, 32'h3f80_0000, 32'h4020_0000, 32'h7f80_0000,
            32'hff80_0000, 32'h7f80_0001, 32'hffc0_0000, 32'h4b00_0000, 32'hcb00_0000,
            32'h7f7f_ffff, 32'hff7f_ffff, 32'h0000_0001, 32'h8000_0001, 32'h007f_ffff,
            32'h3e99_999a, 32'h3f33_3333, 32'h3fa0_0000, 32'h3e7f_ffff, 32'h4090_0000};
    foreach (vals[i]) send_x(vals[i]);
    wait_drain();
  endtask

  task automatic test_random();
    repeat (300) send_x(rand_x());
    wait_drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        rx_hold = 1'b1;
        repeat (150) @(negedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    repeat (75) send_x(rand_x());
    wait_drain();
  endtask

  initial begin
    err_cnt     = 0;
    cycle_cnt   = 0;
    burst_left  = 0;
    rx_hold     = 1'b0;
    rx_mode     = 0;
    in_valid_i  = 1'b0;
    x_bits_i    = 32'd0;
    out_ready_i = 1'b0;
    rst_ni      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    if (err_cnt == 0) $display("tb_tanpi_float32: clean");
    else $display("tb_tanpi_float32: errors");
    $finish;
  end

endmodule
